FILE: src/pose_constant_velocity_predict_defines.svh
// Assertion macros used by the pose predictor controller.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef POSE_CONSTANT_VELOCITY_PREDICT_DEFINES_SVH
`define POSE_CONSTANT_VELOCITY_PREDICT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define PCVP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcvp: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define PCVP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcvp: next-cycle check failed");

`endif

FILE: src/pcvp_pkg.sv
// ----------------------------------------------------------------------------
// pcvp_pkg
// Types, operation codes and constants shared by the pose predictor's
// controller and datapath.
// ----------------------------------------------------------------------------
package pcvp_pkg;

  localparam int unsigned IN_W  = 200;
  localparam int unsigned OUT_W = 224;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE        = 5'd0;
  localparam op_t OP_LOAD        = 5'd1;
  localparam op_t OP_MUL_POS     = 5'd2;
  localparam op_t OP_ACC_POS     = 5'd3;
  localparam op_t OP_MUL_ROT     = 5'd4;
  localparam op_t OP_ACC_ROT     = 5'd5;
  localparam op_t OP_MUL_SQ      = 5'd6;
  localparam op_t OP_ACC_SQ      = 5'd7;
  localparam op_t OP_SQRT_INIT   = 5'd8;
  localparam op_t OP_SQRT_STEP   = 5'd9;
  localparam op_t OP_QID         = 5'd10;
  localparam op_t OP_QTINY       = 5'd11;
  localparam op_t OP_MUL_RCP     = 5'd12;
  localparam op_t OP_DIV_INIT_Q  = 5'd13;
  localparam op_t OP_DIV_STEP    = 5'd14;
  localparam op_t OP_CORDIC_INIT = 5'd15;
  localparam op_t OP_CORDIC_STEP = 5'd16;
  localparam op_t OP_TRIG_DONE   = 5'd17;
  localparam op_t OP_MUL_Q       = 5'd18;
  localparam op_t OP_QSET        = 5'd19;
  localparam op_t OP_MUL_O       = 5'd20;
  localparam op_t OP_ACC_O       = 5'd21;
  localparam op_t OP_RND         = 5'd22;
  localparam op_t OP_COMMIT      = 5'd23;
  localparam op_t OP_RCP_QUOT    = 5'd24;
  localparam op_t OP_MUL_HPI     = 5'd25;
  localparam op_t OP_RED_FIX     = 5'd26;

  typedef struct packed {
    op_t        op;
    logic [1:0] k;     // axis, quaternion component or output component
    logic [1:0] t;     // term of the quaternion product
    logic [4:0] step;  // CORDIC iteration
  } cmd_t;

  typedef struct packed {
    logic any_rot;    // rotation vector is nonzero
    logic root_zero;  // integer root of the squared magnitude is zero
  } stat_t;

  localparam logic [31:0]        HALF_PI_Q30 = 32'd1686629713;
  // floor(2^62 / HALF_PI_Q30): root * this >> 53 is the quadrant count or one less.
  localparam logic [31:0]        RCP_HALF_PI = 32'd2734261102;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
  // Negated terms of the Hamilton product, indexed by {component, term}.
  localparam logic [15:0]        HAM_NEG     = 16'h428E;

  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:    v = 31'd843314857;
      5'd1:    v = 31'd497837829;
      5'd2:    v = 31'd263043837;
      5'd3:    v = 31'd133525159;
      5'd4:    v = 31'd67021687;
      5'd5:    v = 31'd33543516;
      5'd6:    v = 31'd16775851;
      5'd7:    v = 31'd8388437;
      5'd8:    v = 31'd4194283;
      5'd9:    v = 31'd2097149;
      5'd10:   v = 31'd1048575;
      default: v = 31'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [67:0] v);
    logic [31:0] r;
    if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -68'sh0_0000_0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/pcvp_datapath.sv
// ----------------------------------------------------------------------------
// pcvp_datapath
// Pose state, shared multiplier, integer root, radix-2 divider, CORDIC and
// output register, driven by the controller with at most one operation per cycle.
// ----------------------------------------------------------------------------
module pcvp_datapath
  import pcvp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic [IN_W-1:0]  in_data,
  output stat_t            stat,
  output logic [OUT_W-1:0] out_data
);

  logic [7:0]         dt_r;
  logic signed [31:0] vel_r  [3];
  logic signed [31:0] rate_r [3];
  logic signed [31:0] pos_r  [3];
  logic signed [31:0] ori_r  [4];
  logic               a_neg_r [3];
  logic [30:0]        a_lo_r  [3];
  logic [30:0]        sv_r    [3];
  logic               any_r;
  logic [63:0]        sum_r;
  logic [63:0]        sq_n_r, sq_res_r, sq_bit_r;
  logic signed [65:0] prod_r;
  logic [63:0]        dnum_r, dquot_r;
  logic [31:0]        drem_r, dden_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [1:0]         quad_r;
  logic signed [31:0] q_r  [4];
  logic [30:0]        sm_r;
  logic               sn_neg_r;
  logic signed [67:0] acc_r;
  logic signed [31:0] nq_r [4];
  logic [OUT_W-1:0]   out_r;

  logic signed [32:0] mul_a, mul_b;
  logic [31:0]        root;

  assign root           = sq_res_r[31:0];
  assign stat.any_rot   = any_r;
  assign stat.root_zero = (root == 32'd0);
  assign out_data       = out_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_POS: begin
        mul_a = {vel_r[cmd.k][31], vel_r[cmd.k]};
        mul_b = {25'd0, dt_r};
      end
      OP_MUL_ROT: begin
        mul_a = {rate_r[cmd.k][31], rate_r[cmd.k]};
        mul_b = {25'd0, dt_r};
      end
      OP_MUL_SQ: begin
        mul_a = {2'd0, sv_r[cmd.k]};
        mul_b = {2'd0, sv_r[cmd.k]};
      end
      OP_MUL_RCP: begin
        mul_a = {1'b0, root};
        mul_b = {1'b0, RCP_HALF_PI};
      end
      OP_MUL_HPI: begin
        mul_a = {1'b0, dquot_r[31:0]};
        mul_b = {1'b0, HALF_PI_Q30};
      end
      OP_MUL_Q: begin
        mul_a = {2'd0, sm_r};
        mul_b = {2'd0, sv_r[cmd.k]};
      end
      OP_MUL_O: begin
        mul_a = {ori_r[cmd.t][31], ori_r[cmd.t]};
        mul_b = {q_r[cmd.k ^ cmd.t][31], q_r[cmd.k ^ cmd.t]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Pose state resets; working registers are only meaningful once loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
      end
      ori_r[0] <= ONE_Q30;
      ori_r[1] <= '0;
      ori_r[2] <= '0;
      ori_r[3] <= '0;
    end else begin
      if (cmd.op == OP_ACC_POS) begin
        pos_r[cmd.k] <= sat32({{26{prod_r[65]}}, prod_r[41:0]}
                              + {{36{pos_r[cmd.k][31]}}, pos_r[cmd.k]});
      end
      if (cmd.op == OP_COMMIT) begin
        for (int i = 0; i < 4; i++) begin
          ori_r[i] <= nq_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [39:0]        mag;
    logic [64:0]        trial;
    logic [32:0]        shl;
    logic [41:0]        red;
    logic signed [33:0] dx, dy, ta;
    logic signed [31:0] cc, ss, cm, sn;
    logic signed [67:0] term, rsum;
    logic [31:0]        qmag;

    mag   = prod_r[65] ? 40'(-prod_r) : prod_r[39:0];
    trial = {1'b0, sq_res_r} + {1'b0, sq_bit_r};
    shl   = {drem_r, dnum_r[63]};
    // Half angle less the estimated whole quadrants; below two quadrants.
    red   = {1'b0, root, 9'd0} - prod_r[41:0];
    dx    = cy_r >>> cmd.step;
    dy    = cx_r >>> cmd.step;
    ta    = {3'd0, atan_q30(cmd.step)};
    cc    = cx_r < 0 ? 32'sd0 : (cx_r > 34'sd1073741824 ? ONE_Q30 : cx_r[31:0]);
    ss    = cy_r < 0 ? 32'sd0 : (cy_r > 34'sd1073741824 ? ONE_Q30 : cy_r[31:0]);
    case (quad_r)
      2'd0:    begin cm = cc;  sn = ss;  end
      2'd1:    begin cm = -ss; sn = cc;  end
      2'd2:    begin cm = -cc; sn = -ss; end
      default: begin cm = ss;  sn = -cc; end
    endcase
    term  = HAM_NEG[{cmd.k, cmd.t}] ? -{{2{prod_r[65]}}, prod_r}
                                    : {{2{prod_r[65]}}, prod_r};
    rsum  = acc_r + 68'sd536870912;
    qmag  = dquot_r[31:0];

    case (cmd.op)
      OP_LOAD: begin
        dt_r      <= in_data[7:0];
        vel_r[0]  <= in_data[39:8];
        vel_r[1]  <= in_data[71:40];
        vel_r[2]  <= in_data[103:72];
        rate_r[0] <= in_data[135:104];
        rate_r[1] <= in_data[167:136];
        rate_r[2] <= in_data[199:168];
        any_r     <= 1'b0;
        sum_r     <= '0;
      end
      OP_MUL_POS, OP_MUL_ROT, OP_MUL_SQ, OP_MUL_RCP, OP_MUL_HPI, OP_MUL_Q,
      OP_MUL_O: begin
        prod_r <= mul_a * mul_b;
      end
      OP_ACC_ROT: begin
        a_neg_r[cmd.k] <= prod_r[65];
        a_lo_r[cmd.k]  <= prod_r[30:0];
        sv_r[cmd.k]    <= mag[38:8];
        any_r          <= any_r | (mag != 40'd0);
      end
      OP_ACC_SQ: begin
        sum_r <= sum_r + prod_r[63:0];
      end
      OP_SQRT_INIT: begin
        sq_n_r   <= sum_r;
        sq_res_r <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if ({1'b0, sq_n_r} >= trial) begin
          sq_n_r   <= sq_n_r - trial[63:0];
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_QID: begin
        q_r[0] <= ONE_Q30;
        q_r[1] <= '0;
        q_r[2] <= '0;
        q_r[3] <= '0;
      end
      OP_QTINY: begin
        q_r[0] <= ONE_Q30;
        q_r[1] <= {a_lo_r[0], 1'b0};
        q_r[2] <= {a_lo_r[1], 1'b0};
        q_r[3] <= {a_lo_r[2], 1'b0};
      end
      OP_RCP_QUOT: begin
        dquot_r <= {53'd0, prod_r[63:53]};
      end
      OP_RED_FIX: begin
        // The reciprocal estimate may fall one quadrant short.
        if (red >= {10'd0, HALF_PI_Q30}) begin
          drem_r  <= 32'(red - {10'd0, HALF_PI_Q30});
          dquot_r <= dquot_r + 64'd1;
        end else begin
          drem_r  <= red[31:0];
        end
      end
      OP_DIV_INIT_Q: begin
        dnum_r  <= prod_r[63:0];
        dden_r  <= root;
        drem_r  <= '0;
        dquot_r <= '0;
      end
      OP_DIV_STEP: begin
        dnum_r <= dnum_r << 1;
        if (shl >= {1'b0, dden_r}) begin
          drem_r  <= 32'(shl - {1'b0, dden_r});
          dquot_r <= {dquot_r[62:0], 1'b1};
        end else begin
          drem_r  <= shl[31:0];
          dquot_r <= {dquot_r[62:0], 1'b0};
        end
      end
      OP_CORDIC_INIT: begin
        quad_r <= dquot_r[1:0];
        cz_r   <= {3'd0, drem_r[30:0]};
        cx_r   <= CORDIC_GAIN;
        cy_r   <= '0;
      end
      OP_CORDIC_STEP: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - ta;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + ta;
        end
      end
      OP_TRIG_DONE: begin
        q_r[0]   <= cm;
        sm_r     <= sn[31] ? 31'(-sn) : sn[30:0];
        sn_neg_r <= sn[31];
      end
      OP_QSET: begin
        q_r[cmd.k + 2'd1] <= (a_neg_r[cmd.k] ^ sn_neg_r) ? -qmag : qmag;
      end
      OP_ACC_O: begin
        acc_r <= (cmd.t == 2'd0 ? 68'sd0 : acc_r) + term;
      end
      OP_RND: begin
        nq_r[cmd.k] <= sat32(rsum >>> 30);
      end
      OP_COMMIT: begin
        out_r <= {nq_r[3], nq_r[2], nq_r[1], nq_r[0], pos_r[2], pos_r[1], pos_r[0]};
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/pcvp_ctrl.sv
// ----------------------------------------------------------------------------
// pcvp_ctrl
// Sequencer of the pose predictor: steps the datapath through one item and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
`include "pose_constant_velocity_predict_defines.svh"

module pcvp_ctrl
  import pcvp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_POS_MUL   = 5'd1;
  localparam logic [4:0] S_POS_ACC   = 5'd2;
  localparam logic [4:0] S_ROT_MUL   = 5'd3;
  localparam logic [4:0] S_ROT_ACC   = 5'd4;
  localparam logic [4:0] S_SQ_MUL    = 5'd5;
  localparam logic [4:0] S_SQ_ACC    = 5'd6;
  localparam logic [4:0] S_SQRT_INIT = 5'd7;
  localparam logic [4:0] S_SQRT      = 5'd8;
  localparam logic [4:0] S_BRANCH    = 5'd9;
  localparam logic [4:0] S_RED_MUL   = 5'd10;
  localparam logic [4:0] S_DIV       = 5'd11;
  localparam logic [4:0] S_TRIG_INIT = 5'd12;
  localparam logic [4:0] S_CORDIC    = 5'd13;
  localparam logic [4:0] S_TRIG_DONE = 5'd14;
  localparam logic [4:0] S_QM_MUL    = 5'd15;
  localparam logic [4:0] S_QDIV_INIT = 5'd16;
  localparam logic [4:0] S_QSET      = 5'd17;
  localparam logic [4:0] S_HAM_MUL   = 5'd18;
  localparam logic [4:0] S_HAM_ACC   = 5'd19;
  localparam logic [4:0] S_RND       = 5'd20;
  localparam logic [4:0] S_COMMIT    = 5'd21;
  localparam logic [4:0] S_RED_QUOT  = 5'd22;
  localparam logic [4:0] S_RED_HPI   = 5'd23;
  localparam logic [4:0] S_RED_FIX   = 5'd24;

  logic [4:0] state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] t_r, t_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_free   = !ov_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    t_nxt     = t_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_tready;
    cmd.op    = OP_NONE;
    cmd.k     = k_r;
    cmd.t     = t_r;
    cmd.step  = cnt_r[4:0];
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          k_nxt     = 2'd0;
          state_nxt = S_POS_MUL;
        end
      end
      S_POS_MUL: begin
        cmd.op    = OP_MUL_POS;
        state_nxt = S_POS_ACC;
      end
      S_POS_ACC: begin
        cmd.op = OP_ACC_POS;
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = S_ROT_MUL;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_POS_MUL;
        end
      end
      S_ROT_MUL: begin
        cmd.op    = OP_MUL_ROT;
        state_nxt = S_ROT_ACC;
      end
      S_ROT_ACC: begin
        cmd.op = OP_ACC_ROT;
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = S_SQ_MUL;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_ROT_MUL;
        end
      end
      S_SQ_MUL: begin
        cmd.op    = OP_MUL_SQ;
        state_nxt = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd.op = OP_ACC_SQ;
        if (k_r == 2'd2) begin
          state_nxt = S_SQRT_INIT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_SQ_MUL;
        end
      end
      S_SQRT_INIT: begin
        cmd.op    = OP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          state_nxt = S_BRANCH;
        end
      end
      S_BRANCH: begin
        k_nxt = 2'd0;
        t_nxt = 2'd0;
        if (!stat.any_rot) begin
          cmd.op    = OP_QID;
          state_nxt = S_HAM_MUL;
        end else if (stat.root_zero) begin
          // Angle below one root step: small-angle quaternion.
          cmd.op    = OP_QTINY;
          state_nxt = S_HAM_MUL;
        end else begin
          state_nxt = S_RED_MUL;
        end
      end
      S_RED_MUL: begin
        cmd.op    = OP_MUL_RCP;
        state_nxt = S_RED_QUOT;
      end
      S_RED_QUOT: begin
        cmd.op    = OP_RCP_QUOT;
        state_nxt = S_RED_HPI;
      end
      S_RED_HPI: begin
        cmd.op    = OP_MUL_HPI;
        state_nxt = S_RED_FIX;
      end
      S_RED_FIX: begin
        cmd.op    = OP_RED_FIX;
        state_nxt = S_TRIG_INIT;
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = S_QSET;
        end
      end
      S_TRIG_INIT: begin
        cmd.op    = OP_CORDIC_INIT;
        cnt_nxt   = '0;
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.op  = OP_CORDIC_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd29) begin
          state_nxt = S_TRIG_DONE;
        end
      end
      S_TRIG_DONE: begin
        cmd.op    = OP_TRIG_DONE;
        k_nxt     = 2'd0;
        state_nxt = S_QM_MUL;
      end
      S_QM_MUL: begin
        cmd.op    = OP_MUL_Q;
        state_nxt = S_QDIV_INIT;
      end
      S_QDIV_INIT: begin
        cmd.op    = OP_DIV_INIT_Q;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_QSET: begin
        cmd.op = OP_QSET;
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          t_nxt     = 2'd0;
          state_nxt = S_HAM_MUL;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_QM_MUL;
        end
      end
      S_HAM_MUL: begin
        cmd.op    = OP_MUL_O;
        state_nxt = S_HAM_ACC;
      end
      S_HAM_ACC: begin
        cmd.op = OP_ACC_O;
        if (t_r == 2'd3) begin
          state_nxt = S_RND;
        end else begin
          t_nxt     = t_r + 2'd1;
          state_nxt = S_HAM_MUL;
        end
      end
      S_RND: begin
        cmd.op = OP_RND;
        t_nxt  = 2'd0;
        if (k_r == 2'd3) begin
          state_nxt = S_COMMIT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_HAM_MUL;
        end
      end
      S_COMMIT: begin
        // Hold the new pose until the output register is free.
        if (out_free) begin
          cmd.op    = OP_COMMIT;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      t_r     <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      t_r     <= t_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  `PCVP_ASSERT_NXT(a_accept_starts, in_tvalid && in_tready, state_r == S_POS_MUL && k_r == 2'd0)
  `PCVP_ASSERT_NXT(a_commit_waits, state_r == S_COMMIT && ov_r && !out_tready, state_r == S_COMMIT && ov_r)
  `PCVP_ASSERT_NXT(a_qdiv_returns, state_r == S_DIV && cnt_r == 6'd63, state_r == S_QSET)
  `PCVP_ASSERT_IMP(a_cordic_bound, state_r == S_CORDIC, cnt_r <= 6'd29)

endmodule

FILE: src/pose_constant_velocity_predict.sv
// ----------------------------------------------------------------------------
// pose_constant_velocity_predict
// Constant-velocity pose predictor: position and orientation quaternion are
// advanced by one time step for every input beat.
// ----------------------------------------------------------------------------
// Usage: one input beat carries a time step and the linear and angular
// velocities; one output beat returns the updated position and quaternion.
// Items are handled one at a time. For a general rotation the result waits
// on the shared radix-2 divider (three 64-step divisions for the axis
// scalings), the 32-step integer root and the 30-step CORDIC; the angle
// reduction multiplies the root by a reciprocal, takes the quadrant
// quotient, multiplies it back by half pi and corrects a short estimate.
// A zero or vanishingly small rotation skips the reduction, the CORDIC and
// the divisions, but not the root. The next input beat is taken once the
// previous result has been placed in the output register.
// Reset puts the position at zero and the orientation at the identity.
// If the receiver stalls, the result waits in the output register; the
// block still accepts and computes the next item, and then holds it until
// the output register is free.
// ----------------------------------------------------------------------------
module pose_constant_velocity_predict
  import pcvp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // time_step[7:0], vel_x, vel_y, vel_z, rate_x, rate_y, rate_z (32 bits each)
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z (32 bits each)
  output logic [OUT_W-1:0] out_tdata
);

  cmd_t  cmd;
  stat_t stat;

  pcvp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pcvp_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_tdata),
    .stat     (stat),
    .out_data (out_tdata)
  );

endmodule
